### src/qrv_pkg.sv
// shared types, widths and a helper function for the quaternion vector rotation core
package qrv_pkg;

   // pipeline depth: two multiply stages, two add stages, one round and clip stage
   localparam int STAGES    = 5;

   // widths of the arithmetic through the pipe
   localparam int IN_W      = 16;
   localparam int PROD1_W   = 2 * IN_W;
   localparam int T_W       = PROD1_W + 1;
   localparam int PROD2_W   = T_W + IN_W;
   localparam int ACC_W     = PROD2_W + 3;
   localparam int FRAC_BITS = 28;
   localparam int SHIFT_W   = ACC_W - FRAC_BITS;

   localparam logic signed [IN_W-1:0] OUT_MAX = IN_W'(32767);
   localparam logic signed [IN_W-1:0] OUT_MIN = IN_W'(-32768);

   // request word: vector and rotation quaternion
   typedef struct packed {
      logic signed [IN_W-1:0] vec_x;
      logic signed [IN_W-1:0] vec_y;
      logic signed [IN_W-1:0] vec_z;
      logic signed [IN_W-1:0] rot_i;
      logic signed [IN_W-1:0] rot_j;
      logic signed [IN_W-1:0] rot_k;
      logic signed [IN_W-1:0] rot_real;
   } req_type;

   // response word: rotated vector and clip flag
   typedef struct packed {
      logic signed [IN_W-1:0] out_x;
      logic signed [IN_W-1:0] out_y;
      logic signed [IN_W-1:0] out_z;
      logic                   clipped;
   } rsp_type;

   // per-stage load enables from the control to the datapath
   typedef struct packed {
      logic [STAGES-1:0] en;
   } qrv_ctrl_type;

   // one saturated component
   typedef struct packed {
      logic signed [IN_W-1:0] val;
      logic                   clip;
   } sat_type;

   // clip a rounded component to the 16-bit signed range
   function automatic sat_type sat16(input logic signed [SHIFT_W-1:0] v);
      sat_type r;
      if (v > SHIFT_W'(OUT_MAX)) begin
         r.val  = OUT_MAX;
         r.clip = 1'b1;
      end else if (v < SHIFT_W'(OUT_MIN)) begin
         r.val  = OUT_MIN;
         r.clip = 1'b1;
      end else begin
         r.val  = v[IN_W-1:0];
         r.clip = 1'b0;
      end
      return r;
   endfunction

endpackage

### src/quaternion_rotate_vector_core.sv
// Throughput: one word per cycle while the output is not stalled;
// five register stages (product, sum, product, sum, round and clip), each 16x16 or
// 33x16 multiply or one wide add per stage.
// A stalled output holds its word while empty stages ahead of it keep filling.
// Reset clears the stage valid bits only; the arithmetic registers are not reset.
// top level: valid/ready stage control around the rotation datapath
module quaternion_rotate_vector_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  qrv_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output qrv_pkg::rsp_type rsp_data
);
   import qrv_pkg::*;

   logic [STAGES-1:0] valid_ff, valid_in;
   qrv_ctrl_type      ctrl;

   // a stage loads when it is empty or its word moves on
   always_comb begin
      ctrl.en[STAGES-1] = !valid_ff[STAGES-1] || rsp_ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         ctrl.en[i] = !valid_ff[i] || ctrl.en[i+1];
      end
   end

   // valid bits follow the data
   always_comb begin
      valid_in[0] = ctrl.en[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < STAGES; i++) begin
         valid_in[i] = ctrl.en[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // arithmetic pipe
   qrv_datapath u_datapath (
      .clock    (clock),
      .ctrl     (ctrl),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   assign req_ready = ctrl.en[0];
   assign rsp_valid = valid_ff[STAGES-1];

endmodule

### src/qrv_datapath.sv
// five-stage arithmetic pipe forming q * v * conj(q) with rounding and saturation
module qrv_datapath (
   input  logic                 clock,
   input  qrv_pkg::qrv_ctrl_type ctrl,
   input  qrv_pkg::req_type     req_data,
   output qrv_pkg::rsp_type     rsp_data
);
   import qrv_pkg::*;

   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(2 ** (FRAC_BITS - 1));

   // stage 1: first products, quaternion carried along
   logic signed [PROD1_W-1:0] wvx_ff, yvz_ff, zvy_ff;
   logic signed [PROD1_W-1:0] wvy_ff, xvz_ff, zvx_ff;
   logic signed [PROD1_W-1:0] wvz_ff, xvy_ff, yvx_ff;
   logic signed [PROD1_W-1:0] xvx_ff, yvy_ff, zvz_ff;
   logic signed [IN_W-1:0]    x1_ff, y1_ff, z1_ff, w1_ff;

   // stage 2: intermediate quaternion t = q * v
   logic signed [T_W-1:0]     tx_ff, ty_ff, tz_ff, tw_ff;
   logic signed [T_W-1:0]     tx_in, ty_in, tz_in, tw_in;
   logic signed [IN_W-1:0]    x2_ff, y2_ff, z2_ff, w2_ff;

   // stage 3: second products t * conj(q)
   logic signed [PROD2_W-1:0] twx_ff, txw_ff, tyz_ff, tzy_ff;
   logic signed [PROD2_W-1:0] twy_ff, txz_ff, tyw_ff, tzx_ff;
   logic signed [PROD2_W-1:0] twz_ff, txy_ff, tyx_ff, tzw_ff;

   // stage 4: sums with the rounding offset folded in
   logic signed [ACC_W-1:0]   ax_ff, ay_ff, az_ff;
   logic signed [ACC_W-1:0]   ax_in, ay_in, az_in;

   // stage 5: output register
   rsp_type                   rsp_ff, rsp_in;
   logic signed [SHIFT_W-1:0] sx, sy, sz;
   sat_type                   cx, cy, cz;

   // first products
   always_ff @(posedge clock) begin
      if (ctrl.en[0]) begin
         wvx_ff <= PROD1_W'(req_data.rot_real) * PROD1_W'(req_data.vec_x);
         yvz_ff <= PROD1_W'(req_data.rot_j)    * PROD1_W'(req_data.vec_z);
         zvy_ff <= PROD1_W'(req_data.rot_k)    * PROD1_W'(req_data.vec_y);
         wvy_ff <= PROD1_W'(req_data.rot_real) * PROD1_W'(req_data.vec_y);
         xvz_ff <= PROD1_W'(req_data.rot_i)    * PROD1_W'(req_data.vec_z);
         zvx_ff <= PROD1_W'(req_data.rot_k)    * PROD1_W'(req_data.vec_x);
         wvz_ff <= PROD1_W'(req_data.rot_real) * PROD1_W'(req_data.vec_z);
         xvy_ff <= PROD1_W'(req_data.rot_i)    * PROD1_W'(req_data.vec_y);
         yvx_ff <= PROD1_W'(req_data.rot_j)    * PROD1_W'(req_data.vec_x);
         xvx_ff <= PROD1_W'(req_data.rot_i)    * PROD1_W'(req_data.vec_x);
         yvy_ff <= PROD1_W'(req_data.rot_j)    * PROD1_W'(req_data.vec_y);
         zvz_ff <= PROD1_W'(req_data.rot_k)    * PROD1_W'(req_data.vec_z);
         x1_ff  <= req_data.rot_i;
         y1_ff  <= req_data.rot_j;
         z1_ff  <= req_data.rot_k;
         w1_ff  <= req_data.rot_real;
      end
   end

   // t = q * (v, 0)
   always_comb begin
      tx_in = T_W'(wvx_ff) + T_W'(yvz_ff) - T_W'(zvy_ff);
      ty_in = T_W'(wvy_ff) - T_W'(xvz_ff) + T_W'(zvx_ff);
      tz_in = T_W'(wvz_ff) + T_W'(xvy_ff) - T_W'(yvx_ff);
      tw_in = -(T_W'(xvx_ff) + T_W'(yvy_ff) + T_W'(zvz_ff));
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[1]) begin
         tx_ff <= tx_in;
         ty_ff <= ty_in;
         tz_ff <= tz_in;
         tw_ff <= tw_in;
         x2_ff <= x1_ff;
         y2_ff <= y1_ff;
         z2_ff <= z1_ff;
         w2_ff <= w1_ff;
      end
   end

   // second products, signs applied in the sum stage
   always_ff @(posedge clock) begin
      if (ctrl.en[2]) begin
         twx_ff <= PROD2_W'(tw_ff) * PROD2_W'(x2_ff);
         txw_ff <= PROD2_W'(tx_ff) * PROD2_W'(w2_ff);
         tyz_ff <= PROD2_W'(ty_ff) * PROD2_W'(z2_ff);
         tzy_ff <= PROD2_W'(tz_ff) * PROD2_W'(y2_ff);
         twy_ff <= PROD2_W'(tw_ff) * PROD2_W'(y2_ff);
         txz_ff <= PROD2_W'(tx_ff) * PROD2_W'(z2_ff);
         tyw_ff <= PROD2_W'(ty_ff) * PROD2_W'(w2_ff);
         tzx_ff <= PROD2_W'(tz_ff) * PROD2_W'(x2_ff);
         twz_ff <= PROD2_W'(tw_ff) * PROD2_W'(z2_ff);
         txy_ff <= PROD2_W'(tx_ff) * PROD2_W'(y2_ff);
         tyx_ff <= PROD2_W'(ty_ff) * PROD2_W'(x2_ff);
         tzw_ff <= PROD2_W'(tz_ff) * PROD2_W'(w2_ff);
      end
   end

   // vector part of t * conj(q) plus half an lsb of the output scale
   always_comb begin
      ax_in = ROUND_HALF - ACC_W'(twx_ff) + ACC_W'(txw_ff) - ACC_W'(tyz_ff) + ACC_W'(tzy_ff);
      ay_in = ROUND_HALF - ACC_W'(twy_ff) + ACC_W'(txz_ff) + ACC_W'(tyw_ff) - ACC_W'(tzx_ff);
      az_in = ROUND_HALF - ACC_W'(twz_ff) - ACC_W'(txy_ff) + ACC_W'(tyx_ff) + ACC_W'(tzw_ff);
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[3]) begin
         ax_ff <= ax_in;
         ay_ff <= ay_in;
         az_ff <= az_in;
      end
   end

   // floor shift gives round half up, then clip to 16 bits
   always_comb begin
      sx = signed'(ax_ff[ACC_W-1:FRAC_BITS]);
      sy = signed'(ay_ff[ACC_W-1:FRAC_BITS]);
      sz = signed'(az_ff[ACC_W-1:FRAC_BITS]);
      cx = sat16(sx);
      cy = sat16(sy);
      cz = sat16(sz);
      rsp_in.out_x   = cx.val;
      rsp_in.out_y   = cy.val;
      rsp_in.out_z   = cz.val;
      rsp_in.clipped = cx.clip | cy.clip | cz.clip;
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[4]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

### src/qrv_checker.sv
// port-level checks for the rotation core, bound to the top level
module qrv_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input qrv_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input qrv_pkg::rsp_type rsp_data
);
   import qrv_pkg::*;

   // nothing comes out in the cycle after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a waiting request word holds until it is taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("waiting req word changed");

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp word changed");

   // a free output means the whole pipe moves, so the input is open
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_ready || !rsp_valid) |-> req_ready)
      else $error("req_ready low with free output");

   // a clip flag comes with at least one component at a rail
   a_clip_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.clipped |->
         rsp_data.out_x == OUT_MAX || rsp_data.out_x == OUT_MIN ||
         rsp_data.out_y == OUT_MAX || rsp_data.out_y == OUT_MIN ||
         rsp_data.out_z == OUT_MAX || rsp_data.out_z == OUT_MIN)
      else $error("clipped set with no component saturated");

endmodule

bind quaternion_rotate_vector_core qrv_checker u_qrv_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
